/* rtl/core/prt_pkg.sv */
package prt_pkg;

  localparam int unsigned Slots     = 16;
  localparam int unsigned SlotW     = 4;
  localparam int unsigned CntW      = 5;
  localparam int unsigned InstW     = 6;
  localparam int unsigned PortW     = 4;
  localparam int unsigned CmdW      = 8;
  localparam int unsigned TimeW     = 16;

  localparam logic [TimeW-1:0] DefaultTimeoutReset = 16'd3000;

  localparam logic [1:0] OpSend     = 2'd0;
  localparam logic [1:0] OpResponse = 2'd1;
  localparam logic [1:0] OpTick     = 2'd2;

  localparam logic [1:0] KindSendAck   = 2'd0;
  localparam logic [1:0] KindResponse  = 2'd1;
  localparam logic [1:0] KindTimeout   = 2'd2;
  localparam logic [1:0] KindTickEmpty = 2'd3;

  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusTableFull = 2'd1;
  localparam logic [1:0] StatusNoMatch   = 2'd2;

  typedef struct packed {
    logic [PortW-1:0] port;
    logic [CmdW-1:0]  cmd;
    logic [InstW-1:0] inst;
    logic [TimeW-1:0] remaining;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

/* rtl/core/pending_request_tracker.sv */
// Pending request tracker. Each beat on the input stream is one operation: a send (which
// assigns an instance id to a request and stores it in the lowest free of 16 slots), a
// response (which removes the oldest matching entry), or a tick (which ages all entries and
// reports every expired one, oldest first, with tlast on the final report). Entries live in a
// single-port-write, registered-read RAM; send order is kept in a small list of slot numbers.
// A send writes its entry and loads its acknowledgement together. A response walks the list one
// stored entry at a time, reading each from the RAM and then checking it. A tick makes two
// walks, one to age the entries and one to report expiries; the second is skipped when nothing
// expires. An output stall holds an operation whenever it has a result to load. The input is
// taken only between operations; a finished result may still wait in the output register.
module pending_request_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,     // default_timeout

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // port_id[3:0], cmd[11:4], resp_inst_id[17:12], req_timeout[33:18], elapsed_ms[49:34]
  input  logic [55:0] s_axis_tdata,
  // op[1:0], is_request[2]
  input  logic [2:0]  s_axis_tuser,

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], out_inst_id[7:2], out_cmd[15:8], out_port[19:16], slot[23:20]
  output logic [23:0] m_axis_tdata,
  // kind[1:0]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  typedef enum logic [1:0] {
    StIdle,
    StSend,
    StRead,
    StCheck
  } state_e;

  localparam int unsigned SlotW = prt_pkg::SlotW;
  localparam int unsigned CntW  = prt_pkg::CntW;
  localparam int unsigned InstW = prt_pkg::InstW;
  localparam int unsigned Slots = prt_pkg::Slots;

  state_e state_q;

  logic [1:0]                  op_q;
  logic [prt_pkg::PortW-1:0]   port_q;
  logic [prt_pkg::CmdW-1:0]    cmd_q;
  logic [prt_pkg::InstW-1:0]   rinst_q;
  logic                        isreq_q;
  logic [prt_pkg::TimeW-1:0]   tmo_q;
  logic [prt_pkg::TimeW-1:0]   elapsed_q;

  logic [prt_pkg::TimeW-1:0]   default_q;
  logic [prt_pkg::InstW-1:0]   next_inst_q;
  logic [Slots-1:0]            valid_q;
  logic [SlotW-1:0]            order_q [Slots];
  logic [CntW-1:0]             cnt_q;
  logic [CntW-1:0]             pos_q;
  logic [CntW-1:0]             exp_q;
  logic                        phase_q;
  logic [SlotW-1:0]            cur_slot_q;

  logic                        out_valid_q;
  logic [1:0]                  out_kind_q;
  logic [1:0]                  out_status_q;
  logic [prt_pkg::InstW-1:0]   out_inst_q;
  logic [prt_pkg::CmdW-1:0]    out_cmd_q;
  logic [prt_pkg::PortW-1:0]   out_port_q;
  logic [SlotW-1:0]            out_slot_q;
  logic                        out_last_q;

  logic                        out_free;
  logic                        out_load;
  logic [SlotW-1:0]            free_slot;
  logic                        full;
  logic                        at_end;
  prt_pkg::entry_t             rd_entry;
  prt_pkg::entry_t             wr_entry;
  logic [prt_pkg::TimeW-1:0]   aged;
  logic                        ram_we;
  logic [SlotW-1:0]            ram_waddr;
  logic                        ram_re;
  logic                        is_match;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == StIdle);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign full          = (cnt_q == CntW'(Slots));
  assign at_end        = (pos_q == cnt_q);

  always_comb begin
    free_slot = '0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_slot = SlotW'(i);
      end
    end
  end

  assign aged     = (rd_entry.remaining > elapsed_q) ? rd_entry.remaining - elapsed_q : '0;
  assign is_match = (rd_entry.inst == rinst_q) && (rd_entry.port == port_q)
                    && (rd_entry.cmd == cmd_q);

  always_comb begin
    unique case (state_q)
      StSend: begin
        out_load = out_free;
      end
      StRead: begin
        out_load = out_free && at_end
                   && ((op_q == prt_pkg::OpResponse) || (!phase_q && exp_q == '0));
      end
      StCheck: begin
        out_load = out_free && !(op_q == prt_pkg::OpTick && !phase_q)
                   && ((op_q == prt_pkg::OpTick) ? (rd_entry.remaining == '0) : is_match);
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_slot_q;
    wr_entry  = rd_entry;
    if (state_q == StSend) begin
      ram_waddr          = free_slot;
      wr_entry.port      = port_q;
      wr_entry.cmd       = cmd_q;
      wr_entry.inst      = next_inst_q;
      wr_entry.remaining = (tmo_q != '0) ? tmo_q : default_q;
      ram_we             = out_free && isreq_q && !full;
    end else if (state_q == StCheck && op_q == prt_pkg::OpTick && !phase_q) begin
      wr_entry.remaining = aged;
      ram_we             = 1'b1;
    end
  end

  assign ram_re = (state_q == StRead) && !at_end;

  prt_ram #(
    .Width(prt_pkg::EntryW),
    .Depth(Slots)
  ) u_entries (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(wr_entry),
    .re_i   (ram_re),
    .raddr_i(order_q[pos_q[SlotW-1:0]]),
    .rdata_o(rd_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      default_q   <= prt_pkg::DefaultTimeoutReset;
      next_inst_q <= '0;
      valid_q     <= '0;
      cnt_q       <= '0;
      pos_q       <= '0;
      exp_q       <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        default_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (s_axis_tvalid) begin
            op_q      <= s_axis_tuser[1:0];
            isreq_q   <= s_axis_tuser[2];
            port_q    <= s_axis_tdata[3:0];
            cmd_q     <= s_axis_tdata[11:4];
            rinst_q   <= s_axis_tdata[17:12];
            tmo_q     <= s_axis_tdata[33:18];
            elapsed_q <= s_axis_tdata[49:34];
            pos_q     <= '0;
            exp_q     <= '0;
            phase_q   <= 1'b0;
            unique case (s_axis_tuser[1:0]) inside
              prt_pkg::OpSend:                      state_q <= StSend;
              prt_pkg::OpResponse, prt_pkg::OpTick: state_q <= StRead;
              default:                              state_q <= StIdle;
            endcase
          end
        end
        StSend: begin
          if (out_free) begin
            out_kind_q   <= prt_pkg::KindSendAck;
            out_status_q <= (isreq_q && full) ? prt_pkg::StatusTableFull : prt_pkg::StatusOk;
            out_inst_q   <= isreq_q ? next_inst_q : '0;
            out_cmd_q    <= cmd_q;
            out_port_q   <= port_q;
            out_slot_q   <= (isreq_q && !full) ? free_slot : '0;
            out_last_q   <= 1'b1;
            if (isreq_q) begin
              next_inst_q <= next_inst_q + InstW'(1);
              if (!full) begin
                valid_q[free_slot]          <= 1'b1;
                order_q[cnt_q[SlotW-1:0]]   <= free_slot;
                cnt_q                       <= cnt_q + CntW'(1);
              end
            end
            state_q <= StIdle;
          end
        end
        StRead: begin
          if (!at_end) begin
            cur_slot_q <= order_q[pos_q[SlotW-1:0]];
            state_q    <= StCheck;
          end else if (op_q == prt_pkg::OpResponse) begin
            if (out_free) begin
              out_kind_q   <= prt_pkg::KindResponse;
              out_status_q <= prt_pkg::StatusNoMatch;
              out_inst_q   <= rinst_q;
              out_cmd_q    <= cmd_q;
              out_port_q   <= port_q;
              out_slot_q   <= '0;
              out_last_q   <= 1'b1;
              state_q      <= StIdle;
            end
          end else if (phase_q) begin
            state_q <= StIdle;
          end else if (exp_q != '0) begin
            phase_q <= 1'b1;
            pos_q   <= '0;
          end else if (out_free) begin
            out_kind_q   <= prt_pkg::KindTickEmpty;
            out_status_q <= prt_pkg::StatusOk;
            out_inst_q   <= '0;
            out_cmd_q    <= '0;
            out_port_q   <= '0;
            out_slot_q   <= '0;
            out_last_q   <= 1'b1;
            state_q      <= StIdle;
          end
        end
        StCheck: begin
          if (op_q == prt_pkg::OpTick && !phase_q) begin
            if (aged == '0) begin
              exp_q <= exp_q + CntW'(1);
            end
            pos_q   <= pos_q + CntW'(1);
            state_q <= StRead;
          end else if ((op_q == prt_pkg::OpTick) ? (rd_entry.remaining == '0) : is_match) begin
            if (out_free) begin
              out_kind_q   <= (op_q == prt_pkg::OpTick) ? prt_pkg::KindTimeout
                                                        : prt_pkg::KindResponse;
              out_status_q <= prt_pkg::StatusOk;
              out_inst_q   <= rd_entry.inst;
              out_cmd_q    <= rd_entry.cmd;
              out_port_q   <= rd_entry.port;
              out_slot_q   <= cur_slot_q;
              out_last_q   <= (op_q == prt_pkg::OpTick) ? (exp_q == CntW'(1)) : 1'b1;
              valid_q[cur_slot_q] <= 1'b0;
              for (int j = 0; j < Slots - 1; j++) begin
                if (CntW'(j) >= pos_q) begin
                  order_q[j] <= order_q[j+1];
                end
              end
              cnt_q   <= cnt_q - CntW'(1);
              exp_q   <= exp_q - CntW'(1);
              state_q <= (op_q == prt_pkg::OpTick) ? StRead : StIdle;
            end
          end else begin
            pos_q   <= pos_q + CntW'(1);
            state_q <= StRead;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_slot_q, out_port_q, out_cmd_q, out_inst_q, out_status_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule

/* rtl/core/prt_ram.sv */
module prt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* tb/sv/pending_request_tracker_test.sv */
module pending_request_tracker_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Slots = prt_pkg::Slots;
  localparam int unsigned SlotW = prt_pkg::SlotW;
  localparam int unsigned InstW = prt_pkg::InstW;
  localparam int unsigned PortW = prt_pkg::PortW;
  localparam int unsigned CmdW  = prt_pkg::CmdW;
  localparam int unsigned TimeW = prt_pkg::TimeW;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam int unsigned IdleCycles = 100;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned RandomPhases = 5;
  localparam int unsigned BeatsPerPhase = 32;

  typedef struct packed {
    logic [1:0]       op;
    logic [PortW-1:0] port;
    logic [CmdW-1:0]  cmd;
    logic [InstW-1:0] rinst;
    logic             is_req;
    logic [TimeW-1:0] tmo;
    logic [TimeW-1:0] elapsed;
  } tracker_op_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       status;
    logic [InstW-1:0] inst;
    logic [CmdW-1:0]  cmd;
    logic [PortW-1:0] port;
    logic [SlotW-1:0] slot;
    logic             last;
  } tracker_result_t;

  typedef struct packed {
    logic            is_cfg;
    logic [TimeW-1:0] cfg_value;
    logic [4:0]      reps;
    tracker_op_t     beat;
    logic            typed;
    tracker_result_t want;
  } plan_row_t;

  localparam tracker_op_t     NoBeat   = '0;
  localparam tracker_result_t NoResult = '0;

  localparam int unsigned PlanRows = 23;
  localparam plan_row_t Plan [PlanRows] = '{
    '{1'b0, 16'd0, 5'd1, '{prt_pkg::OpTick, 4'h0, 8'h00, 6'h00, 1'b0, 16'h0000, 16'h0000},
      1'b1, '{prt_pkg::KindTickEmpty, prt_pkg::StatusOk, 6'h00, 8'h00, 4'h0, 4'h0, 1'b1}},
    '{1'b0, 16'd0, 5'd1, '{prt_pkg::OpResponse, 4'hF, 8'hFF, 6'h3F, 1'b0, 16'h0000, 16'h0000},
      1'b1, '{prt_pkg::KindResponse, prt_pkg::StatusNoMatch, 6'h3F, 8'hFF, 4'hF, 4'h0, 1'b1}},
    '{1'b0, 16'd0, 5'd1, '{prt_pkg::OpSend, 4'hF, 8'hAA, 6'h3F, 1'b0, 16'hFFFF, 16'hFFFF},
      1'b1, '{prt_pkg::KindSendAck, prt_pkg::StatusOk, 6'h00, 8'hAA, 4'hF, 4'h0, 1'b1}},
    '{1'b0, 16'd0, 5'd1, '{OpUnused, 4'hF, 8'hFF, 6'h3F, 1'b1, 16'hFFFF, 16'hFFFF},
      1'b0, NoResult},
    '{1'b0, 16'd0, 5'd1, '{prt_pkg::OpSend, 4'h0, 8'h00, 6'h00, 1'b1, 16'h0000, 16'h0000},
      1'b1, '{prt_pkg::KindSendAck, prt_pkg::StatusOk, 6'h00, 8'h00, 4'h0, 4'h0, 1'b1}},
    '{1'b0, 16'd0, 5'd1, '{prt_pkg::OpSend, 4'hF, 8'hFF, 6'h00, 1'b1, 16'hFFFF, 16'h0000},
      1'b0, NoResult},
    '{1'b0, 16'd0, 5'd2, '{prt_pkg::OpSend, 4'h5, 8'h3C, 6'h00, 1'b1, 16'h0001, 16'h0000},
      1'b0, NoResult},
    '{1'b0, 16'd0, 5'd1, '{prt_pkg::OpResponse, 4'hF, 8'hFF, 6'h01, 1'b0, 16'h0000, 16'h0000},
      1'b0, NoResult},
    '{1'b0, 16'd0, 5'd1, '{prt_pkg::OpResponse, 4'hF, 8'hFF, 6'h01, 1'b0, 16'h0000, 16'h0000},
      1'b0, NoResult},
    '{1'b0, 16'd0, 5'd1, '{prt_pkg::OpTick, 4'h0, 8'h00, 6'h00, 1'b0, 16'h0000, 16'h0001},
      1'b0, NoResult},
    '{1'b0, 16'd0, 5'd1, '{prt_pkg::OpTick, 4'h0, 8'h00, 6'h00, 1'b0, 16'h0000, 16'hFFFF},
      1'b0, NoResult},
    '{1'b0, 16'd0, 5'd1, '{prt_pkg::OpTick, 4'h0, 8'h00, 6'h00, 1'b0, 16'h0000, 16'h0000},
      1'b0, NoResult},
    '{1'b0, 16'd0, 5'd17, '{prt_pkg::OpSend, 4'hA, 8'h5A, 6'h00, 1'b1, 16'h0000, 16'h0000},
      1'b0, NoResult},
    '{1'b0, 16'd0, 5'd1, '{prt_pkg::OpResponse, 4'hA, 8'h5A, 6'h04, 1'b0, 16'h0000, 16'h0000},
      1'b0, NoResult},
    '{1'b0, 16'd0, 5'd1, '{prt_pkg::OpTick, 4'h0, 8'h00, 6'h00, 1'b0, 16'h0000, 16'hFFFF},
      1'b0, NoResult},
    '{1'b1, 16'h0000, 5'd0, NoBeat, 1'b0, NoResult},
    '{1'b0, 16'd0, 5'd1, '{prt_pkg::OpSend, 4'h3, 8'hC3, 6'h00, 1'b1, 16'h0000, 16'h0000},
      1'b0, NoResult},
    '{1'b0, 16'd0, 5'd1, '{prt_pkg::OpTick, 4'h0, 8'h00, 6'h00, 1'b0, 16'h0000, 16'h0000},
      1'b0, NoResult},
    '{1'b1, 16'hFFFF, 5'd0, NoBeat, 1'b0, NoResult},
    '{1'b0, 16'd0, 5'd1, '{prt_pkg::OpSend, 4'h3, 8'hC3, 6'h00, 1'b1, 16'h0000, 16'h0000},
      1'b0, NoResult},
    '{1'b0, 16'd0, 5'd1, '{prt_pkg::OpTick, 4'h0, 8'h00, 6'h00, 1'b0, 16'h0000, 16'hFFFE},
      1'b0, NoResult},
    '{1'b0, 16'd0, 5'd1, '{prt_pkg::OpTick, 4'h0, 8'h00, 6'h00, 1'b0, 16'h0000, 16'h0001},
      1'b0, NoResult},
    '{1'b1, 16'h0001, 5'd0, NoBeat, 1'b0, NoResult}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  logic             pend_valid [Slots];
  logic [PortW-1:0] pend_port  [Slots];
  logic [CmdW-1:0]  pend_cmd   [Slots];
  logic [InstW-1:0] pend_inst  [Slots];
  logic [TimeW-1:0] pend_left  [Slots];
  logic [SlotW-1:0] pend_age   [Slots];
  int               pend_count;
  logic [InstW-1:0] next_id;
  logic [TimeW-1:0] dflt_timeout;

  tracker_result_t op_results [$];
  tracker_result_t awaited_results [$];
  bit              failed = 1'b0;
  bit              calm = 1'b0;
  int              stall_left = 0;
  int unsigned     cycle_count = 0;

  pending_request_tracker i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (!calm && stall_left == 0 && $urandom_range(0, 5) == 0) begin
      stall_left    <= $urandom_range(1, 7);
      m_axis_tready <= 1'b0;
    end else if (stall_left > 1) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      stall_left    <= 0;
      m_axis_tready <= 1'b1;
    end
  end

  function automatic void retire_entry(input int s);
    int i;
    for (i = 0; i < Slots; i++) begin
      if (pend_valid[i] && pend_age[i] > pend_age[s]) pend_age[i] = pend_age[i] - SlotW'(1);
    end
    pend_valid[s] = 1'b0;
    if (pend_count > 0) pend_count--;
  endfunction

  // Advances the tracker state by one operation and leaves its reports in op_results.
  function automatic void advance_tracker(input tracker_op_t b);
    tracker_result_t r;
    int              i;
    int              best;
    int              n;
    op_results.delete();
    r = '0;
    r.last = 1'b1;
    case (b.op)
      prt_pkg::OpSend: begin
        r.kind = prt_pkg::KindSendAck;
        r.cmd  = b.cmd;
        r.port = b.port;
        if (b.is_req) begin
          r.inst  = next_id;
          next_id = next_id + InstW'(1);
          best    = -1;
          for (i = 0; i < Slots; i++) begin
            if (!pend_valid[i] && best < 0) best = i;
          end
          if (best < 0) begin
            r.status = prt_pkg::StatusTableFull;
          end else begin
            pend_valid[best] = 1'b1;
            pend_port[best]  = b.port;
            pend_cmd[best]   = b.cmd;
            pend_inst[best]  = r.inst;
            pend_left[best]  = (b.tmo != 0) ? b.tmo : dflt_timeout;
            pend_age[best]   = SlotW'(pend_count);
            pend_count++;
            r.slot = SlotW'(best);
          end
        end
        op_results.push_back(r);
      end
      prt_pkg::OpResponse: begin
        r.kind = prt_pkg::KindResponse;
        best   = -1;
        for (i = 0; i < Slots; i++) begin
          if (pend_valid[i] && pend_inst[i] == b.rinst && pend_port[i] == b.port &&
              pend_cmd[i] == b.cmd && (best < 0 || pend_age[i] < pend_age[best])) best = i;
        end
        r.inst = b.rinst;
        r.cmd  = b.cmd;
        r.port = b.port;
        if (best < 0) begin
          r.status = prt_pkg::StatusNoMatch;
        end else begin
          r.slot = SlotW'(best);
          retire_entry(best);
        end
        op_results.push_back(r);
      end
      prt_pkg::OpTick: begin
        for (i = 0; i < Slots; i++) begin
          if (pend_valid[i]) pend_left[i] = (pend_left[i] > b.elapsed) ?
                                             pend_left[i] - b.elapsed : '0;
        end
        n = 0;
        do begin
          best = -1;
          for (i = 0; i < Slots; i++) begin
            if (pend_valid[i] && pend_left[i] == 0 &&
                (best < 0 || pend_age[i] < pend_age[best])) best = i;
          end
          if (best >= 0) begin
            r        = '0;
            r.kind   = prt_pkg::KindTimeout;
            r.status = prt_pkg::StatusOk;
            r.inst   = pend_inst[best];
            r.cmd    = pend_cmd[best];
            r.port   = pend_port[best];
            r.slot   = SlotW'(best);
            op_results.push_back(r);
            retire_entry(best);
            n++;
          end
        end while (best >= 0 && n < Slots);
        if (n == 0) begin
          r      = '0;
          r.kind = prt_pkg::KindTickEmpty;
          op_results.push_back(r);
        end
        r      = op_results.pop_back();
        r.last = 1'b1;
        op_results.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function automatic tracker_op_t draw_op();
    tracker_op_t b;
    int          roll;
    int          s;
    b.port    = PortW'($urandom_range(0, 15));
    b.cmd     = CmdW'($urandom_range(0, 255));
    b.rinst   = InstW'($urandom_range(0, 63));
    b.is_req  = 1'($urandom_range(0, 1));
    b.tmo     = TimeW'($urandom_range(0, 65535));
    b.elapsed = TimeW'($urandom_range(0, 65535));
    roll      = $urandom_range(0, 99);
    if (roll < 35) begin
      b.op     = prt_pkg::OpSend;
      b.is_req = 1'b1;
      roll     = $urandom_range(0, 9);
      if (roll < 3) b.tmo = '0;
      else if (roll < 9) b.tmo = TimeW'($urandom_range(1, 200));
    end else if (roll < 45) begin
      b.op     = prt_pkg::OpSend;
      b.is_req = 1'b0;
    end else if (roll < 70) begin
      b.op = prt_pkg::OpResponse;
      if (pend_count > 0 && $urandom_range(0, 3) != 0) begin
        s = $urandom_range(0, Slots - 1);
        while (!pend_valid[s]) s = (s + 1) % Slots;
        b.port  = pend_port[s];
        b.cmd   = pend_cmd[s];
        b.rinst = pend_inst[s];
      end
    end else if (roll < 95) begin
      b.op = prt_pkg::OpTick;
      if ($urandom_range(0, 9) != 9) b.elapsed = TimeW'($urandom_range(0, 120));
    end else begin
      b.op = OpUnused;
    end
    return b;
  endfunction

  task automatic feed_beat(input tracker_op_t b);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {6'd0, b.elapsed, b.tmo, b.rinst, b.cmd, b.port};
    s_axis_tuser  <= {b.is_req, b.op};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic set_default_timeout(input logic [TimeW-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (IdleCycles) @(posedge clk_i);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i  <= 1'b0;
    dflt_timeout = value;
  endtask

  function automatic void note_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      failed = 1'b1;
    end
  endfunction

  always @(posedge clk_i) begin : watch_results
    tracker_result_t got;
    tracker_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind   = m_axis_tuser;
      got.status = m_axis_tdata[1:0];
      got.inst   = m_axis_tdata[7:2];
      got.cmd    = m_axis_tdata[15:8];
      got.port   = m_axis_tdata[19:16];
      got.slot   = m_axis_tdata[23:20];
      got.last   = m_axis_tlast;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got %h", $time, got);
        failed = 1'b1;
      end else begin
        want = awaited_results.pop_front();
        note_field("kind", int'(want.kind), int'(got.kind));
        note_field("status", int'(want.status), int'(got.status));
        note_field("out_inst_id", int'(want.inst), int'(got.inst));
        note_field("out_cmd", int'(want.cmd), int'(got.cmd));
        note_field("out_port", int'(want.port), int'(got.port));
        note_field("slot", int'(want.slot), int'(got.slot));
        note_field("last", int'(want.last), int'(got.last));
      end
    end
  end

  initial begin : run
    int          k;
    int          rep;
    int          ph;
    int          cnt;
    tracker_op_t b;
    for (k = 0; k < Slots; k++) pend_valid[k] = 1'b0;
    pend_count   = 0;
    next_id      = '0;
    dflt_timeout = prt_pkg::DefaultTimeoutReset;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < PlanRows; k++) begin
      if (Plan[k].is_cfg) begin
        set_default_timeout(Plan[k].cfg_value);
      end else begin
        for (rep = 0; rep < int'(Plan[k].reps); rep++) begin
          advance_tracker(Plan[k].beat);
          if (Plan[k].typed) awaited_results.push_back(Plan[k].want);
          else foreach (op_results[i]) awaited_results.push_back(op_results[i]);
          feed_beat(Plan[k].beat);
        end
      end
    end

    for (ph = 0; ph < RandomPhases; ph++) begin
      case (ph)
        0: set_default_timeout(16'hFFFF);
        1: set_default_timeout(16'h0001);
        2: set_default_timeout(TimeW'($urandom_range(1, 400)));
        default: set_default_timeout(TimeW'($urandom_range(1, 65535)));
      endcase
      calm = (ph == RandomPhases - 1) || ($urandom_range(0, 3) == 0);
      cnt  = 0;
      while (cnt < BeatsPerPhase) begin
        b = draw_op();
        advance_tracker(b);
        foreach (op_results[i]) awaited_results.push_back(op_results[i]);
        feed_beat(b);
        if (b.op != OpUnused) cnt++;
      end
    end

    s_axis_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (IdleCycles) @(posedge clk_i);
    if (failed) begin
      $display("status: fail");
    end else begin
      $display("status: pass");
    end
    $finish;
  end

endmodule
